@@ hdl/rdq_pkg.sv @@
// Shared types and constants of the request dispatch queue.
// No dependencies; compile first.
package rdq_pkg;

  // Command codes carried on the command channel
  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_PROCESS = 2'd1,
    ACT_UNDO    = 2'd2,
    ACT_LOOKUP  = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Field widths fixed by the channel format
  localparam int ID_W   = 9;
  localparam int TS_W   = 8;
  localparam int TYPE_W = 2;
  localparam int PRIO_W = 2;
  localparam int ZONE_W = 3;
  localparam int REC_W  = TYPE_W + PRIO_W + ZONE_W;

  // Type and priority use codes 0..2
  localparam logic [TYPE_W-1:0] CODE_COUNT = 2'd3;

  // Stored request record
  typedef struct packed {
    logic [TYPE_W-1:0] rtype;
    logic [PRIO_W-1:0] prio;
    logic [ZONE_W-1:0] zone;
  } rec_t;

endpackage

@@ hdl/rdq_cmd_if.sv @@
// Command channel of the request dispatch queue (valid/ready).
// Depends on rdq_pkg.
interface rdq_cmd_if;
  import rdq_pkg::*;

  logic                valid;
  logic                ready;
  action_e             action;
  logic [TYPE_W-1:0]   request_type;
  logic [PRIO_W-1:0]   request_priority;
  logic [ZONE_W-1:0]   request_zone;
  logic [ID_W-1:0]     query_id;

  modport source (
    output valid, action, request_type, request_priority, request_zone, query_id,
    input  ready
  );
  modport sink (
    input  valid, action, request_type, request_priority, request_zone, query_id,
    output ready
  );
endinterface

@@ hdl/rdq_rsp_if.sv @@
// Response channel of the request dispatch queue (valid/ready).
// Depends on rdq_pkg.
interface rdq_rsp_if;
  import rdq_pkg::*;

  logic                valid;
  logic                ready;
  status_e             status;
  logic [ID_W-1:0]     result_id;
  logic [TYPE_W-1:0]   result_type;
  logic [PRIO_W-1:0]   result_priority;
  logic [ZONE_W-1:0]   result_zone;
  logic [TS_W-1:0]     result_timestamp;
  logic [ID_W-1:0]     pending_count;
  logic [ID_W-1:0]     processed_count;

  modport source (
    output valid, status, result_id, result_type, result_priority, result_zone,
           result_timestamp, pending_count, processed_count,
    input  ready
  );
  modport sink (
    input  valid, status, result_id, result_type, result_priority, result_zone,
           result_timestamp, pending_count, processed_count,
    output ready
  );
endinterface

@@ hdl/rdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdq_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/request_dispatch_queue_with_undo_top.sv @@
// Request dispatch queue with undo: top level.
// Depends on rdq_pkg, rdq_cmd_if, rdq_rsp_if and rdq_ram.
//
// Takes one command per clock while the command channel is not stalled and
// returns one response per command, in order, through the registered read
// of the record, pending and processed RAMs and then the output register.
// Queue pointers and counts are updated when the command is taken; the RAM
// writes are made as the entry leaves the stage register, and a bypass
// register per RAM hands that write to a command read at the same address
// on the same edge. Pending and processed entries carry the request record
// with the id, so each command uses the read data of at most one RAM. No
// clearing pass is needed after reset. The command channel stalls only while
// the output register is full and not being taken.
module request_dispatch_queue_with_undo_top #(
  parameter int MAX_REQUESTS = 256,
  parameter int ZONE_COUNT   = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdq_cmd_if.sink   cmd_i,
  rdq_rsp_if.source rsp_o
);
  import rdq_pkg::*;

  localparam int NW = $clog2(MAX_REQUESTS + 1);   // ids and counts
  localparam int PW = $clog2(MAX_REQUESTS);       // RAM addresses
  localparam int CW = (NW > ID_W) ? NW : ID_W;    // common compare width
  localparam int EW = NW + REC_W;                 // pending/processed entry

  localparam logic [NW-1:0]     MAX_N    = NW'(MAX_REQUESTS);
  localparam logic [PW-1:0]     PTR_LAST = PW'(MAX_REQUESTS - 1);
  localparam logic [ZONE_W:0]   ZONE_LIM = (ZONE_W + 1)'(ZONE_COUNT);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Queue state
  logic [NW-1:0] assigned_q, assigned_d;
  logic [NW-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [NW-1:0] stk_dep_q, stk_dep_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;

  // Stage register
  logic          s1_vld_q;
  action_e       s1_act_q;
  status_e       s1_st_q, st_d;
  logic [NW-1:0] s1_id_q, id_d;
  rec_t          s1_rec_q;
  logic [PW-1:0] s1_fwa_q;   // pending write address
  logic [PW-1:0] s1_wb_q, wb_d;  // record or processed write address
  logic [NW-1:0] s1_fcnt_q, s1_scnt_q;

  // Output register
  logic          out_vld_q;
  status_e       out_st_q;
  logic [ID_W-1:0] out_id_q, out_fcnt_q, out_scnt_q;
  rec_t          out_rec_q;
  logic [TS_W-1:0] out_ts_q;

  logic cmd_acc, s1_adv;

  assign s1_adv      = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign cmd_i.ready = !s1_vld_q || s1_adv;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Command decode against current state
  rec_t          in_rec;
  logic [CW-1:0] qid_cw, asg_cw, qid_m1;
  logic [NW-1:0] dep_m1;

  always_comb begin
    in_rec     = '{rtype: cmd_i.request_type, prio: cmd_i.request_priority,
                   zone: cmd_i.request_zone};
    qid_cw     = CW'(cmd_i.query_id);
    asg_cw     = CW'(assigned_q);
    qid_m1     = qid_cw - 1'b1;
    dep_m1     = stk_dep_q - 1'b1;
    st_d       = ST_OK;
    id_d       = '0;
    wb_d       = stk_dep_q[PW-1:0];
    assigned_d = assigned_q;
    fifo_cnt_d = fifo_cnt_q;
    stk_dep_d  = stk_dep_q;
    head_d     = head_q;
    tail_d     = tail_q;
    case (cmd_i.action)
      ACT_ADD: begin
        wb_d = assigned_q[PW-1:0];
        if (cmd_i.request_type >= CODE_COUNT || cmd_i.request_priority >= CODE_COUNT ||
            {1'b0, cmd_i.request_zone} >= ZONE_LIM) begin
          st_d = ST_INVALID;
        end else if (assigned_q == MAX_N || fifo_cnt_q == MAX_N) begin
          st_d = ST_FULL;
        end else begin
          id_d       = assigned_q + 1'b1;
          assigned_d = assigned_q + 1'b1;
          tail_d     = ptr_inc(tail_q);
          fifo_cnt_d = fifo_cnt_q + 1'b1;
        end
      end
      ACT_PROCESS: begin
        if (fifo_cnt_q == '0) begin
          st_d = ST_EMPTY;
        end else if (stk_dep_q == MAX_N) begin
          st_d = ST_FULL;
        end else begin
          head_d     = ptr_inc(head_q);
          fifo_cnt_d = fifo_cnt_q - 1'b1;
          stk_dep_d  = stk_dep_q + 1'b1;
        end
      end
      ACT_UNDO: begin
        if (stk_dep_q == '0) begin
          st_d = ST_EMPTY;
        end else if (fifo_cnt_q == MAX_N) begin
          st_d = ST_FULL;
        end else begin
          stk_dep_d  = dep_m1;
          tail_d     = ptr_inc(tail_q);
          fifo_cnt_d = fifo_cnt_q + 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (qid_cw != '0 && qid_cw <= asg_cw) begin
          id_d = qid_cw[NW-1:0];
        end else begin
          st_d = ST_EMPTY;
        end
      end
      default: begin
        st_d = ST_INVALID;
      end
    endcase
  end

  // Queue state and stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_q <= '0;
      fifo_cnt_q <= '0;
      stk_dep_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      s1_vld_q   <= 1'b0;
    end else begin
      if (cmd_acc) begin
        assigned_q <= assigned_d;
        fifo_cnt_q <= fifo_cnt_d;
        stk_dep_q  <= stk_dep_d;
        head_q     <= head_d;
        tail_q     <= tail_d;
        s1_vld_q   <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      s1_act_q  <= cmd_i.action;
      s1_st_q   <= st_d;
      s1_id_q   <= id_d;
      s1_rec_q  <= in_rec;
      s1_fwa_q  <= tail_q;
      s1_wb_q   <= wb_d;
      s1_fcnt_q <= fifo_cnt_d;
      s1_scnt_q <= stk_dep_d;
    end
  end

  // RAM ports
  logic             rec_we, fifo_we, stk_we;
  logic [REC_W-1:0] rec_wd, rec_rd;
  logic [EW-1:0]    fifo_wd, fifo_rd, stk_wd, stk_rd;
  logic [PW-1:0]    rec_ra, stk_ra;

  assign rec_ra = qid_m1[PW-1:0];
  assign stk_ra = dep_m1[PW-1:0];

  rdq_ram #(.WIDTH(REC_W), .DEPTH(MAX_REQUESTS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (s1_wb_q),
    .wdata_i (rec_wd),
    .re_i    (cmd_acc),
    .raddr_i (rec_ra),
    .rdata_o (rec_rd)
  );

  rdq_ram #(.WIDTH(EW), .DEPTH(MAX_REQUESTS)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (s1_fwa_q),
    .wdata_i (fifo_wd),
    .re_i    (cmd_acc),
    .raddr_i (head_q),
    .rdata_o (fifo_rd)
  );

  rdq_ram #(.WIDTH(EW), .DEPTH(MAX_REQUESTS)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (s1_wb_q),
    .wdata_i (stk_wd),
    .re_i    (cmd_acc),
    .raddr_i (stk_ra),
    .rdata_o (stk_rd)
  );

  // Bypass of a write landing on the address read at the same edge
  logic             rec_byp_q, fifo_byp_q, stk_byp_q;
  logic [REC_W-1:0] rec_bd_q;
  logic [EW-1:0]    fifo_bd_q, stk_bd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_byp_q  <= 1'b0;
      fifo_byp_q <= 1'b0;
      stk_byp_q  <= 1'b0;
    end else if (cmd_acc) begin
      rec_byp_q  <= rec_we && (s1_wb_q == rec_ra);
      fifo_byp_q <= fifo_we && (s1_fwa_q == head_q);
      stk_byp_q  <= stk_we && (s1_wb_q == stk_ra);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      rec_bd_q  <= rec_wd;
      fifo_bd_q <= fifo_wd;
      stk_bd_q  <= stk_wd;
    end
  end

  // Stage logic: pick read data, drive writes, form the response
  logic          s1_ok;
  logic [REC_W-1:0] rec_ent;
  logic [EW-1:0] fifo_ent, stk_ent;
  logic [NW-1:0] res_id;
  rec_t          res_rec;
  logic [CW-1:0] id_cw, ts_cw, fcnt_cw, scnt_cw;

  always_comb begin
    s1_ok    = (s1_st_q == ST_OK);
    rec_ent  = rec_byp_q  ? rec_bd_q  : rec_rd;
    fifo_ent = fifo_byp_q ? fifo_bd_q : fifo_rd;
    stk_ent  = stk_byp_q  ? stk_bd_q  : stk_rd;

    rec_we  = s1_adv && s1_ok && (s1_act_q == ACT_ADD);
    fifo_we = s1_adv && s1_ok && (s1_act_q == ACT_ADD || s1_act_q == ACT_UNDO);
    stk_we  = s1_adv && s1_ok && (s1_act_q == ACT_PROCESS);
    rec_wd  = s1_rec_q;
    fifo_wd = (s1_act_q == ACT_ADD) ? {s1_id_q, s1_rec_q} : stk_ent;
    stk_wd  = fifo_ent;

    case (s1_act_q)
      ACT_ADD: begin
        res_id  = s1_id_q;
        res_rec = s1_rec_q;
      end
      ACT_PROCESS: begin
        res_id  = fifo_ent[EW-1:REC_W];
        res_rec = fifo_ent[REC_W-1:0];
      end
      ACT_UNDO: begin
        res_id  = stk_ent[EW-1:REC_W];
        res_rec = stk_ent[REC_W-1:0];
      end
      default: begin
        res_id  = s1_id_q;
        res_rec = rec_ent;
      end
    endcase
    if (!s1_ok) begin
      res_id  = '0;
      res_rec = '0;
    end

    id_cw   = CW'(res_id);
    ts_cw   = s1_ok ? (id_cw - 1'b1) : '0;
    fcnt_cw = CW'(s1_fcnt_q);
    scnt_cw = CW'(s1_scnt_q);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_st_q   <= s1_st_q;
      out_id_q   <= id_cw[ID_W-1:0];
      out_rec_q  <= res_rec;
      out_ts_q   <= ts_cw[TS_W-1:0];
      out_fcnt_q <= fcnt_cw[ID_W-1:0];
      out_scnt_q <= scnt_cw[ID_W-1:0];
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.status           = out_st_q;
  assign rsp_o.result_id        = out_id_q;
  assign rsp_o.result_type      = out_rec_q.rtype;
  assign rsp_o.result_priority  = out_rec_q.prio;
  assign rsp_o.result_zone      = out_rec_q.zone;
  assign rsp_o.result_timestamp = out_ts_q;
  assign rsp_o.pending_count    = out_fcnt_q;
  assign rsp_o.processed_count  = out_scnt_q;

`ifndef SYNTH
  // Every assigned id is either pending or processed
  a_id_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fifo_cnt_q} + {1'b0, stk_dep_q}) == {1'b0, assigned_q})
    else $error("pending plus processed differs from assigned ids");

  // Ring pointers agree with the pending count
  a_ring_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) |-> (fifo_cnt_q == '0 || fifo_cnt_q == MAX_N))
    else $error("pending ring pointers meet with a partial count");

  a_ring_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != tail_q) |-> (fifo_cnt_q != '0 && fifo_cnt_q != MAX_N))
    else $error("pending ring pointers apart with empty or full count");

  // A failed command reports no request
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q != ST_OK) |-> (out_id_q == '0 && out_ts_q == '0))
    else $error("failed transaction carries request fields");
`endif

endmodule

@@ sim/tb_request_dispatch_queue_with_undo_top.sv @@
`timescale 1ns / 100ps
// Testbench for the request dispatch queue with undo: predicts every response
// from its own copy of the record store, pending FIFO and processed stack.
// Depends on rdq_pkg, rdq_cmd_if, rdq_rsp_if and the top level.
module tb_request_dispatch_queue_with_undo_top;
  import rdq_pkg::*;

  localparam int MAX_REQ     = 256;
  localparam int ZONES       = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;

  // One response as the block should present it
  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] rtype;
    logic [PRIO_W-1:0] prio;
    logic [ZONE_W-1:0] zone;
    logic [TS_W-1:0]   stamp;
    logic [ID_W-1:0]   n_pending;
    logic [ID_W-1:0]   n_processed;
  } dispatch_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rdq_cmd_if cmd_if ();
  rdq_rsp_if rsp_if ();

  request_dispatch_queue_with_undo_top #(
    .MAX_REQUESTS(MAX_REQ),
    .ZONE_COUNT  (ZONES)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  // Predictor state
  rec_t             req_records [1:MAX_REQ];
  int               queued_ids[$];
  int               handled_ids[$];
  int               next_req_id = 1;
  dispatch_result_t awaited_results[$];

  int fail_count      = 0;
  int cycle_count     = 0;
  int rsp_hold_cycles = 0;
  bit idle_en         = 1'b1;

  // 2 ns clock
  always #1 clk = ~clk;

  // Compute the response to one command and advance the predicted state
  function automatic dispatch_result_t predict_dispatch(
    action_e act, logic [TYPE_W-1:0] rt, logic [PRIO_W-1:0] rp,
    logic [ZONE_W-1:0] rz, logic [ID_W-1:0] qid);
    dispatch_result_t r;
    int id;
    r = '0;
    r.status = ST_OK;
    id = 0;
    case (act)
      ACT_ADD: begin
        // Field check comes ahead of the fullness check
        if (rt >= CODE_COUNT || rp >= CODE_COUNT || rz >= ZONES) begin
          r.status = ST_INVALID;
        end else if (next_req_id > MAX_REQ || queued_ids.size() >= MAX_REQ) begin
          r.status = ST_FULL;
        end else begin
          id = next_req_id;
          req_records[id] = '{rtype: rt, prio: rp, zone: rz};
          next_req_id++;
          queued_ids = {queued_ids, id};
        end
      end
      ACT_PROCESS: begin
        if (queued_ids.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (handled_ids.size() >= MAX_REQ) begin
          r.status = ST_FULL;
        end else begin
          id = queued_ids.pop_front();
          handled_ids = {handled_ids, id};
        end
      end
      ACT_UNDO: begin
        if (handled_ids.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (queued_ids.size() >= MAX_REQ) begin
          r.status = ST_FULL;
        end else begin
          id = handled_ids.pop_back();
          queued_ids = {queued_ids, id};
        end
      end
      default: begin
        if (qid >= 1 && qid < next_req_id && qid <= MAX_REQ) begin
          id = qid;
        end else begin
          r.status = ST_EMPTY;
        end
      end
    endcase
    // Record fields stay zero on any failed command
    if (r.status == ST_OK) begin
      r.id    = id[ID_W-1:0];
      r.rtype = req_records[id].rtype;
      r.prio  = req_records[id].prio;
      r.zone  = req_records[id].zone;
      r.stamp = TS_W'(id - 1);
    end
    r.n_pending   = ID_W'(queued_ids.size());
    r.n_processed = ID_W'(handled_ids.size());
    return r;
  endfunction

  // Offer one command, wait for its transaction, then record the prediction
  task automatic send_cmd(action_e act, logic [TYPE_W-1:0] rt,
                          logic [PRIO_W-1:0] rp, logic [ZONE_W-1:0] rz,
                          logic [ID_W-1:0] qid);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_if.valid            <= 1'b1;
    cmd_if.action           <= act;
    cmd_if.request_type     <= rt;
    cmd_if.request_priority <= rp;
    cmd_if.request_zone     <= rz;
    cmd_if.query_id         <= qid;
    do @(posedge clk); while (!cmd_if.ready);
    awaited_results = {awaited_results, predict_dispatch(act, rt, rp, rz, qid)};
  endtask

  // Random command: mostly well-formed adds and lookups near assigned ids
  task automatic send_random_cmd();
    int pick;
    action_e act;
    logic [TYPE_W-1:0] rt;
    logic [PRIO_W-1:0] rp;
    logic [ZONE_W-1:0] rz;
    logic [ID_W-1:0] qid;
    pick = $urandom_range(0, 99);
    if (pick < 35)      act = ACT_ADD;
    else if (pick < 60) act = ACT_PROCESS;
    else if (pick < 75) act = ACT_UNDO;
    else                act = ACT_LOOKUP;
    rt  = TYPE_W'($urandom_range(0, 3));
    rp  = PRIO_W'($urandom_range(0, 3));
    rz  = ZONE_W'($urandom_range(0, 7));
    qid = ID_W'($urandom_range(0, 511));
    if (act == ACT_ADD && $urandom_range(0, 99) < 85) begin
      rt = TYPE_W'($urandom_range(0, 2));
      rp = PRIO_W'($urandom_range(0, 2));
      rz = ZONE_W'($urandom_range(0, ZONES - 1));
    end
    if (act == ACT_LOOKUP && $urandom_range(0, 99) < 80)
      qid = ID_W'($urandom_range(0, next_req_id));
    send_cmd(act, rt, rp, rz, qid);
  endtask

  // Commands against an empty block
  task automatic test_empty_start();
    send_cmd(ACT_PROCESS, 0, 0, 0, 0);
    send_cmd(ACT_UNDO, 0, 0, 0, 0);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 0);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 1);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 511);
  endtask

  // Field extremes, each invalid selection, and every command
  task automatic test_field_extremes();
    send_cmd(ACT_ADD, 0, 0, 0, 0);
    send_cmd(ACT_ADD, 2, 2, 4, 511);
    send_cmd(ACT_ADD, 3, 0, 0, 0);
    send_cmd(ACT_ADD, 0, 3, 0, 0);
    send_cmd(ACT_ADD, 0, 0, 5, 0);
    send_cmd(ACT_ADD, 3, 3, 7, 0);
    send_cmd(ACT_LOOKUP, 3, 3, 7, 1);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 2);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 3);
    send_cmd(ACT_PROCESS, 3, 3, 7, 511);
    send_cmd(ACT_UNDO, 3, 3, 7, 511);
    send_cmd(ACT_PROCESS, 0, 0, 0, 0);
    send_cmd(ACT_PROCESS, 0, 0, 0, 0);
    send_cmd(ACT_PROCESS, 0, 0, 0, 0);
    send_cmd(ACT_UNDO, 0, 0, 0, 0);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_cmd();
  endtask

  // Response side holds off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    rsp_hold_cycles = 200;
    repeat (30) send_random_cmd();
  endtask

  // Use up every id, then move all ids to the FIFO and all to the stack
  task automatic test_store_full();
    while (next_req_id <= MAX_REQ)
      send_cmd(ACT_ADD, TYPE_W'($urandom_range(0, 2)), PRIO_W'($urandom_range(0, 2)),
               ZONE_W'($urandom_range(0, ZONES - 1)), ID_W'($urandom_range(0, 511)));
    send_cmd(ACT_ADD, 2, 2, 4, 0);
    send_cmd(ACT_ADD, 0, 0, 0, 0);
    send_cmd(ACT_ADD, 3, 1, 1, 0);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 256);
    send_cmd(ACT_LOOKUP, 0, 0, 0, 257);
    while (handled_ids.size() != 0) send_cmd(ACT_UNDO, 0, 0, 0, 0);
    send_cmd(ACT_ADD, 1, 1, 1, 0);
    while (queued_ids.size() != 0) send_cmd(ACT_PROCESS, 0, 0, 0, 0);
    send_cmd(ACT_PROCESS, 0, 0, 0, 0);
    send_cmd(ACT_UNDO, 0, 0, 0, 0);
  endtask

  // Stimulus sequence
  initial begin
    rst_n                   <= 1'b0;
    cmd_if.valid            <= 1'b0;
    cmd_if.action           <= ACT_ADD;
    cmd_if.request_type     <= '0;
    cmd_if.request_priority <= '0;
    cmd_if.request_zone     <= '0;
    cmd_if.query_id         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_start();
    test_field_extremes();
    test_random_traffic(500);
    test_backpressure();
    test_store_full();
    test_random_traffic(500);
    idle_en = 1'b0;
    test_random_traffic(150);

    cmd_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Response side: random stall bursts, plus a long hold when requested
  initial begin
    int n;
    forever begin
      if (rsp_hold_cycles > 0) begin
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each response transaction against the oldest prediction
  always @(posedge clk) begin
    dispatch_result_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: response with none expected: status %0d id %0d",
                 $time, rsp_if.status, rsp_if.result_id);
        fail_count++;
      end else begin
        e = awaited_results.pop_front();
        check_field("status", e.status, rsp_if.status);
        check_field("result_id", e.id, rsp_if.result_id);
        check_field("result_type", e.rtype, rsp_if.result_type);
        check_field("result_priority", e.prio, rsp_if.result_priority);
        check_field("result_zone", e.zone, rsp_if.result_zone);
        check_field("result_timestamp", e.stamp, rsp_if.result_timestamp);
        check_field("pending_count", e.n_pending, rsp_if.pending_count);
        check_field("processed_count", e.n_processed, rsp_if.processed_count);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d responses outstanding", $time, awaited_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ request_dispatch_queue_with_undo_top.f @@
hdl/rdq_pkg.sv
hdl/rdq_cmd_if.sv
hdl/rdq_rsp_if.sv
hdl/rdq_ram.sv
hdl/request_dispatch_queue_with_undo_top.sv
sim/tb_request_dispatch_queue_with_undo_top.sv
